### rtl/tkc_pkg.sv
package tkc_pkg;

	localparam int MAX_KEY_BYTES = 256;
	// Counts saturate at MAX_KEY_BYTES + 1
	localparam int CNT_W = $clog2(MAX_KEY_BYTES + 2);

	localparam int KEY_TYPE_W = 3;
	localparam int BYTE_W = 8;
	localparam int ORDER_W = 2;

	typedef logic [KEY_TYPE_W-1:0] key_type_t;
	typedef logic [CNT_W-1:0] key_cnt_t;
	typedef logic signed [ORDER_W-1:0] order_t;

	localparam key_type_t KT_STRING = 3'd0;
	localparam key_type_t KT_SINT32 = 3'd1;
	localparam key_type_t KT_UINT32 = 3'd2;
	localparam key_type_t KT_SINT64 = 3'd3;
	localparam key_type_t KT_UINT64 = 3'd4;

	localparam order_t ORD_LESS = -2'sd1;
	localparam order_t ORD_EQUAL = 2'sd0;
	localparam order_t ORD_GREATER = 2'sd1;

	localparam key_cnt_t CNT_MAX = CNT_W'(MAX_KEY_BYTES);
	localparam key_cnt_t CNT_SAT = CNT_W'(MAX_KEY_BYTES + 1);
	localparam key_cnt_t WIDTH_32 = CNT_W'(4);
	localparam key_cnt_t WIDTH_64 = CNT_W'(8);

	function automatic order_t order_of_bytes(input logic [BYTE_W-1:0] x,
	                                          input logic [BYTE_W-1:0] y);
		if (x < y)
			return ORD_LESS;
		else if (x > y)
			return ORD_GREATER;
		else
			return ORD_EQUAL;
	endfunction

	function automatic order_t order_of_counts(input key_cnt_t x, input key_cnt_t y);
		if (x < y)
			return ORD_LESS;
		else if (x > y)
			return ORD_GREATER;
		else
			return ORD_EQUAL;
	endfunction

endpackage

### rtl/typed_key_comparator_unit.sv
// Typed key comparator: orders two keys presented side by side, one byte pair
// per input transaction (a_byte/a_present, b_byte/b_present). The transaction
// with final_position high closes the comparison and yields one result
// transaction (order: -1, 0 or 1; too_long if either key went past
// MAX_KEY_BYTES). Other transactions yield no result.
// key_type selects string order or 32/64-bit little-endian integer order;
// write it through cfg_write_en/cfg_write_data only while the block is idle.
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low.
// A final input transaction is captured in the input register, and the compare step
// runs on it into the result register; a held result can keep it waiting there.
// Throughput: one input transaction per cycle while in_stall is low; the compare
// and count update run on the registered input byte pair.
// When out_stall holds a result, a following final transaction waits in the
// input register and in_stall rises; non-final transactions keep flowing.
// Reset (arst_n low) clears key_type to string mode, the comparison state
// and both valid flags.
module typed_key_comparator_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  tkc_pkg::key_type_t          cfg_write_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [tkc_pkg::BYTE_W-1:0]  a_byte,
	input  logic                        a_present,
	input  logic [tkc_pkg::BYTE_W-1:0]  b_byte,
	input  logic                        b_present,
	input  logic                        final_position,
	output logic                        out_valid,
	input  logic                        out_stall,
	output tkc_pkg::order_t             order,
	output logic                        too_long
);
	import tkc_pkg::*;

	key_type_t key_type_q;

	logic valid_s1;
	logic [BYTE_W-1:0] a_byte_s1;
	logic a_present_s1;
	logic [BYTE_W-1:0] b_byte_s1;
	logic b_present_s1;
	logic final_s1;

	order_t first_diff_q;
	order_t last_diff_q;
	key_cnt_t a_cnt_q;
	key_cnt_t b_cnt_q;
	logic overflow_q;

	logic out_valid_q;
	order_t order_q;
	logic too_long_q;

	logic advance;
	key_cnt_t key_width;
	key_cnt_t key_width_m1;
	logic is_signed;
	logic cmp_en;
	order_t byte_ord;
	order_t top_ord;
	order_t first_diff_d;
	order_t last_diff_d;
	key_cnt_t a_cnt_d;
	key_cnt_t b_cnt_d;
	logic overflow_d;
	order_t result_ord;

	// A final item needs the result register free; others always move on
	assign advance = valid_s1 && (!final_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_comb begin
		case (key_type_q)
			KT_SINT32, KT_UINT32: key_width = WIDTH_32;
			KT_SINT64, KT_UINT64: key_width = WIDTH_64;
			default: key_width = '0;
		endcase
		is_signed = (key_type_q == KT_SINT32) || (key_type_q == KT_SINT64);
		key_width_m1 = key_width - key_cnt_t'(1);
	end

	always_comb begin
		cmp_en = a_present_s1 && b_present_s1 && (a_cnt_q < CNT_MAX) && (b_cnt_q < CNT_MAX);
		byte_ord = order_of_bytes(a_byte_s1, b_byte_s1);
		// Top byte of a signed integer: flip the sign bit to compare as signed
		top_ord = order_of_bytes(a_byte_s1 ^ 8'h80, b_byte_s1 ^ 8'h80);

		first_diff_d = first_diff_q;
		last_diff_d = last_diff_q;
		if (cmp_en && byte_ord != ORD_EQUAL) begin
			if (first_diff_q == ORD_EQUAL)
				first_diff_d = byte_ord;
			if (is_signed && key_width != '0 && a_cnt_q == key_width_m1)
				last_diff_d = top_ord;
			else
				last_diff_d = byte_ord;
		end

		a_cnt_d = a_cnt_q;
		b_cnt_d = b_cnt_q;
		overflow_d = overflow_q;
		if (a_present_s1) begin
			if (a_cnt_q < CNT_MAX) begin
				a_cnt_d = a_cnt_q + key_cnt_t'(1);
			end else begin
				a_cnt_d = CNT_SAT;
				overflow_d = 1'b1;
			end
		end
		if (b_present_s1) begin
			if (b_cnt_q < CNT_MAX) begin
				b_cnt_d = b_cnt_q + key_cnt_t'(1);
			end else begin
				b_cnt_d = CNT_SAT;
				overflow_d = 1'b1;
			end
		end

		if (overflow_d)
			result_ord = ORD_EQUAL;
		else if (key_width != '0 && a_cnt_d == key_width && b_cnt_d == key_width)
			result_ord = last_diff_d;
		else if (first_diff_d != ORD_EQUAL)
			result_ord = first_diff_d;
		else
			result_ord = order_of_counts(a_cnt_d, b_cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_type_q <= KT_STRING;
		end else if (cfg_write_en) begin
			key_type_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			a_byte_s1 <= a_byte;
			a_present_s1 <= a_present;
			b_byte_s1 <= b_byte;
			b_present_s1 <= b_present;
			final_s1 <= final_position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_diff_q <= ORD_EQUAL;
			last_diff_q <= ORD_EQUAL;
			a_cnt_q <= '0;
			b_cnt_q <= '0;
			overflow_q <= 1'b0;
		end else if (advance) begin
			if (final_s1) begin
				first_diff_q <= ORD_EQUAL;
				last_diff_q <= ORD_EQUAL;
				a_cnt_q <= '0;
				b_cnt_q <= '0;
				overflow_q <= 1'b0;
			end else begin
				first_diff_q <= first_diff_d;
				last_diff_q <= last_diff_d;
				a_cnt_q <= a_cnt_d;
				b_cnt_q <= b_cnt_d;
				overflow_q <= overflow_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && final_s1) begin
			order_q <= result_ord;
			too_long_q <= overflow_d;
		end
	end

	assign out_valid = out_valid_q;
	assign order = order_q;
	assign too_long = too_long_q;

endmodule

### rtl/tkc_checker.sv
module tkc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input tkc_pkg::order_t             order,
	input logic                        too_long
);
	import tkc_pkg::*;

	// A held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(order) && $stable(too_long))
		else $error("stalled result changed");

	a_order_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (order == ORD_LESS || order == ORD_EQUAL || order == ORD_GREATER))
		else $error("order code out of range");

	a_too_long_equal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && too_long |-> order == ORD_EQUAL)
		else $error("overlong key gave nonzero order");

	// Input only backs up behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result register");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a prior input transaction");

endmodule

bind typed_key_comparator_unit tkc_checker u_tkc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.order     (order),
	.too_long  (too_long)
);

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import tkc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 4;
	localparam int TAIL_CYCLES = 8;
	localparam int PHASE_ITEMS = 28;
	localparam int MAX_REPORTS = 10;
	localparam int KEY_BUF = 300;

	// key_type values with no integer meaning fall back to string order
	localparam key_type_t KT_SPARE5 = 3'd5;
	localparam key_type_t KT_SPARE6 = 3'd6;
	localparam key_type_t KT_SPARE7 = 3'd7;

	class key_order_tracker;
		key_type_t key_type;
		order_t first_diff;
		order_t last_diff;
		int unsigned a_count;
		int unsigned b_count;
		bit overflow;
		order_t expected_order[$];
		bit expected_too_long[$];
		int unsigned mismatches;
		int unsigned compared;

		function new();
			key_type = KT_STRING;
			mismatches = 0;
			compared = 0;
			clear();
		endfunction

		function void clear();
			first_diff = ORD_EQUAL;
			last_diff = ORD_EQUAL;
			a_count = 0;
			b_count = 0;
			overflow = 1'b0;
		endfunction

		function order_t rank(int unsigned x, int unsigned y);
			if (x < y)
				return ORD_LESS;
			if (x > y)
				return ORD_GREATER;
			return ORD_EQUAL;
		endfunction

		function int pending();
			return expected_order.size();
		endfunction

		function void take_byte_pair(logic [7:0] a, logic ap, logic [7:0] b, logic bp,
		                             logic fin);
			int unsigned width;
			bit is_signed;
			order_t d;
			order_t res;
			width = 0;
			if (key_type == KT_SINT32 || key_type == KT_UINT32)
				width = 4;
			else if (key_type == KT_SINT64 || key_type == KT_UINT64)
				width = 8;
			is_signed = (key_type == KT_SINT32 || key_type == KT_SINT64);

			if (ap && bp && a_count < MAX_KEY_BYTES && b_count < MAX_KEY_BYTES) begin
				d = rank(a, b);
				if (d != ORD_EQUAL) begin
					if (first_diff == ORD_EQUAL)
						first_diff = d;
					// top byte of a signed integer key: flip sign bit, compare unsigned
					if (is_signed && width != 0 && a_count == width - 1)
						d = rank(a ^ 8'h80, b ^ 8'h80);
					last_diff = d;
				end
			end
			if (ap) begin
				if (a_count < MAX_KEY_BYTES)
					a_count++;
				else begin
					a_count = MAX_KEY_BYTES + 1;
					overflow = 1'b1;
				end
			end
			if (bp) begin
				if (b_count < MAX_KEY_BYTES)
					b_count++;
				else begin
					b_count = MAX_KEY_BYTES + 1;
					overflow = 1'b1;
				end
			end
			if (!fin)
				return;

			if (overflow)
				res = ORD_EQUAL;
			else if (width != 0 && a_count == width && b_count == width)
				res = last_diff;
			else if (first_diff != ORD_EQUAL)
				res = first_diff;
			else
				res = rank(a_count, b_count);
			expected_order.push_back(res);
			expected_too_long.push_back(overflow);
			clear();
		endfunction

		function void check_order(order_t got_order, logic got_too_long);
			order_t want_order;
			bit want_too_long;
			compared++;
			if (expected_order.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result transaction order=%0d too_long=%0b",
					         $time, got_order, got_too_long);
				return;
			end
			want_order = expected_order.pop_front();
			want_too_long = expected_too_long.pop_front();
			if (got_order !== want_order || got_too_long !== want_too_long) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result %0d: order exp %0d got %0d, too_long exp %0b got %0b",
					         $time, compared, want_order, got_order, want_too_long,
					         got_too_long);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_write_en;
	key_type_t cfg_write_data;
	logic in_valid;
	logic in_stall;
	logic [BYTE_W-1:0] a_byte;
	logic a_present;
	logic [BYTE_W-1:0] b_byte;
	logic b_present;
	logic final_position;
	logic out_valid;
	logic out_stall;
	order_t order;
	logic too_long;

	key_order_tracker tracker = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int unsigned sent_items = 0;
	logic [7:0] key_a [0:KEY_BUF-1];
	logic [7:0] key_b [0:KEY_BUF-1];
	int len_a;
	int len_b;

	typed_key_comparator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.a_byte(a_byte),
		.a_present(a_present),
		.b_byte(b_byte),
		.b_present(b_present),
		.final_position(final_position),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.order(order),
		.too_long(too_long)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
		         tracker.pending());
		$display("typed_key_comparator_unit regression: fail");
		$finish;
	end

	// input side: every accepted transaction goes to the predictor
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			tracker.take_byte_pair(a_byte, a_present, b_byte, b_present, final_position);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_order(order, too_long);
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hff;
			2: return 8'h7f;
			3: return 8'h80;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic push_pair(input logic [7:0] a, input logic ap, input logic [7:0] b,
	                         input logic bp, input logic fin);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		a_byte <= a;
		a_present <= ap;
		b_byte <= b;
		b_present <= bp;
		final_position <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_items++;
	endtask

	// pair of keys, one position per transaction, final on the longer key's end
	task automatic send_keys(input int la, input int lb);
		int n;
		n = (la > lb) ? la : lb;
		if (n == 0)
			push_pair(8'($urandom), 1'b0, 8'($urandom), 1'b0, 1'b1);
		for (int i = 0; i < n; i++)
			push_pair(i < la ? key_a[i] : 8'($urandom), i < la,
			          i < lb ? key_b[i] : 8'($urandom), i < lb, i == n - 1);
	endtask

	// arbitrary presence flags and early finals
	task automatic send_noise(input int n);
		for (int i = 0; i < n; i++)
			push_pair(8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
			          i == n - 1 || $urandom_range(0, 5) == 0);
	endtask

	task automatic make_pair(input key_type_t kt);
		int width;
		int r;
		int top;
		width = (kt == KT_SINT32 || kt == KT_UINT32) ? 4 :
		        (kt == KT_SINT64 || kt == KT_UINT64) ? 8 : 0;
		r = $urandom_range(0, 99);
		if (width != 0 && r < 60) begin
			len_a = width;
			len_b = width;
		end else if (r < 80) begin
			len_a = $urandom_range(0, 10);
			len_b = len_a;
		end else begin
			len_a = $urandom_range(0, 10);
			len_b = $urandom_range(0, 10);
		end
		for (int i = 0; i < len_a; i++)
			key_a[i] = pick_byte();
		for (int i = 0; i < len_b; i++)
			key_b[i] = (i < len_a && $urandom_range(0, 3) != 0) ? key_a[i] : pick_byte();
		// near-equal keys: second copies the first where both have bytes, one byte's bit 7 flipped
		if (len_b > 0 && $urandom_range(0, 4) == 0) begin
			for (int i = 0; i < len_b; i++)
				key_b[i] = (i < len_a) ? key_a[i] : pick_byte();
			top = $urandom_range(0, 1) ? len_b - 1 : $urandom_range(0, len_b - 1);
			key_b[top] = key_b[top] ^ 8'h80;
		end
	endtask

	// waits out all outstanding results, then writes key_type
	task automatic set_key_type(input key_type_t kt);
		in_valid <= 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= kt;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		tracker.key_type = kt;
	endtask

	task automatic run_phase(input key_type_t kt, input int s_pct, input int r_pct);
		int unsigned start;
		set_key_type(kt);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		start = sent_items;
		while (sent_items - start < PHASE_ITEMS) begin
			if ($urandom_range(0, 6) == 0)
				send_noise($urandom_range(1, 5));
			else begin
				make_pair(kt);
				send_keys(len_a, len_b);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_write_en <= 1'b0;
		cfg_write_data <= KT_STRING;
		in_valid <= 1'b0;
		a_byte <= 8'h00;
		a_present <= 1'b0;
		b_byte <= 8'h00;
		b_present <= 1'b0;
		final_position <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed cases
		set_key_type(KT_STRING);
		push_pair(8'h00, 1'b0, 8'h00, 1'b0, 1'b1);   // two empty keys
		push_pair(8'h61, 1'b1, 8'h61, 1'b1, 1'b0);
		push_pair(8'h62, 1'b1, 8'h63, 1'b1, 1'b1);   // less, comes out as 2'b11
		push_pair(8'h61, 1'b1, 8'h61, 1'b1, 1'b0);
		push_pair(8'h62, 1'b1, 8'h00, 1'b0, 1'b1);   // second key is a prefix
		push_pair(8'hff, 1'b1, 8'h00, 1'b1, 1'b1);
		push_pair(8'h10, 1'b1, 8'h00, 1'b0, 1'b0);   // one-sided bytes only count
		push_pair(8'h00, 1'b0, 8'h05, 1'b1, 1'b1);
		set_key_type(KT_SINT32);
		push_pair(8'h01, 1'b1, 8'h00, 1'b1, 1'b0);   // low byte says greater
		push_pair(8'h00, 1'b1, 8'h00, 1'b1, 1'b0);
		push_pair(8'h00, 1'b1, 8'h00, 1'b1, 1'b0);
		push_pair(8'h80, 1'b1, 8'h7f, 1'b1, 1'b1);   // negative top byte wins
		set_key_type(KT_SINT64);
		for (int i = 0; i < 8; i++)
			push_pair(i == 7 ? 8'hff : 8'(i), 1'b1, i == 7 ? 8'h01 : 8'(i), 1'b1, i == 7);

		run_phase(KT_STRING, 10, 45);
		run_phase(KT_SINT32, 10, 45);
		run_phase(KT_UINT64, 10, 45);
		run_phase(KT_SINT64, 45, 10);
		run_phase(KT_SPARE7, 45, 10);
		run_phase(KT_UINT32, 45, 10);
		run_phase(KT_SPARE5, 0, 0);
		run_phase(KT_SINT64, 0, 0);
		run_phase(KT_SPARE6, 0, 0);

		// length bound: first key exactly at the limit, second one byte past it
		set_key_type(KT_STRING);
		for (int i = 0; i < KEY_BUF; i++) begin
			key_a[i] = pick_byte();
			key_b[i] = key_a[i];
		end
		send_keys(MAX_KEY_BYTES, MAX_KEY_BYTES + 1);

		in_valid <= 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d byte-pair transactions in, %0d comparisons checked, key_type 0 to 7",
		         sent_items, tracker.compared);
		$display("empty keys, prefixes, signed top bytes, keys past %0d bytes; %0d mismatches",
		         MAX_KEY_BYTES, tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("typed_key_comparator_unit regression: pass");
		else
			$display("typed_key_comparator_unit regression: fail");
		$finish;
	end

endmodule
